// ===== hw/rtl/integer_pixel_replication_upscaler_top_assert.svh =====
// ---------------------------------------------------------------------------
// upscaler assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef INTEGER_PIXEL_REPLICATION_UPSCALER_TOP_ASSERT_SVH
`define INTEGER_PIXEL_REPLICATION_UPSCALER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define IPRU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define IPRU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define IPRU_ASSERT_IMPL(label, ante, cons, msg)
`define IPRU_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/ipru_pkg.sv =====
// ---------------------------------------------------------------------------
// ipru_pkg
// shared constants and codes of the pixel replication upscaler
// ---------------------------------------------------------------------------
package ipru_pkg;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_SCALE = 128;
	localparam int PIX_W         = 24;
	localparam int SCALE_REG_W   = 8;
	localparam int WIDTH_REG_W   = 11;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	typedef enum logic [1:0] {
		ST_STORED  = 2'd0,
		ST_PIXEL   = 2'd1,
		ST_REFUSED = 2'd2
	} status_t;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_PULL = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_SCALE = 1'b0,
		REG_WIDTH = 1'b1
	} reg_idx_t;

endpackage

// ===== hw/rtl/ipru_in_if.sv =====
// ---------------------------------------------------------------------------
// ipru_in_if
// request channel: push a pixel or pull an output pixel
// ---------------------------------------------------------------------------
interface ipru_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] in_blue;
	logic [7:0] in_green;
	logic [7:0] in_red;

	modport source (output valid, cmd, in_blue, in_green, in_red, input ready);
	modport sink (input valid, cmd, in_blue, in_green, in_red, output ready);
endinterface

// ===== hw/rtl/ipru_out_if.sv =====
// ---------------------------------------------------------------------------
// ipru_out_if
// result channel: one result per request
// ---------------------------------------------------------------------------
interface ipru_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;
	logic       row_end;
	logic       group_end;
	logic [1:0] pad_bytes;

	modport source (output valid, status, out_blue, out_green, out_red, row_end,
		group_end, pad_bytes, input ready);
	modport sink (input valid, status, out_blue, out_green, out_red, row_end,
		group_end, pad_bytes, output ready);
endinterface

// ===== hw/rtl/ipru_line_buf.sv =====
// ---------------------------------------------------------------------------
// ipru_line_buf
// one-row pixel store, one write port and one registered read port
// ---------------------------------------------------------------------------
module ipru_line_buf import ipru_pkg::*; #(
	parameter int DEPTH = DEF_MAX_WIDTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [PIX_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [PIX_W-1:0] rdata
);

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/integer_pixel_replication_upscaler_top.sv =====
// ---------------------------------------------------------------------------
// integer_pixel_replication_upscaler_top
// nearest-neighbor integer upscaler for a 24-bit pixel stream
// ---------------------------------------------------------------------------
// A push request (cmd 0) stores one pixel of the current input row in the
// line buffer; once in_width pixels are in, the row is ready and each pull
// request (cmd 1) returns the next output pixel: every pixel repeated scale
// times across the row, the row replayed scale times. The last pixel of each
// output row carries row_end and the zero-byte count that aligns a 24-bit
// BMP row to 4 bytes; the last pixel of the last replay carries group_end and
// frees the buffer. A push during replay or a pull with no ready row returns
// status 2 and changes nothing. Every request gets exactly one result, in the
// cycle after it is taken, held in an output register until taken. The block
// takes one request per clock, pushes and pulls alike, also while a result
// waits, provided the result side takes one per clock; that figure is set by
// the single write port and single read port of the line buffer and the
// registered update of the column and row counters. The line buffer has no
// clearing pass after reset. Registers: scale at byte address 0, in_width at
// byte address 4; a write to either abandons the row in progress and must
// happen while the block is idle.
// ---------------------------------------------------------------------------
`include "integer_pixel_replication_upscaler_top_assert.svh"

module integer_pixel_replication_upscaler_top import ipru_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_SCALE = DEF_MAX_SCALE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ipru_in_if.sink               pix_in,
	ipru_out_if.source            pix_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	// address and count widths follow from the maximum row length
	localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW  = $clog2(MAX_WIDTH + 1);
	// repeat counters run 0..scale-1, compare width holds scale itself
	localparam int RPW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
	localparam int SW  = $clog2(MAX_SCALE + 1);

	// configuration registers
	logic [SCALE_REG_W-1:0] scale_q;
	logic [WIDTH_REG_W-1:0] in_width_q;

	// row control state
	logic [AW-1:0]  fill_q;
	logic           row_ready_q;
	logic [AW-1:0]  col_q;
	logic [RPW-1:0] col_rep_q;
	logic [RPW-1:0] row_rep_q;

	// result register
	logic       valid_s1;
	status_t    status_s1;
	logic       row_end_s1;
	logic       group_end_s1;
	logic [1:0] pad_s1;

	logic [PIX_W-1:0] rd_pix;

	logic [CW-1:0] eff_w;
	logic [SW-1:0] eff_s;
	logic [1:0]    pad_c;
	logic          cfg_wr;
	logic          accept;
	logic          is_push;
	logic          push_ok;
	logic          pull_ok;
	logic          fill_done;
	logic          col_last;
	logic          col_wrap;
	logic          row_last;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= SCALE_REG_W'(1);
			in_width_q <= WIDTH_REG_W'(1);
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_SCALE: scale_q    <= pwdata[SCALE_REG_W-1:0];
				REG_WIDTH: in_width_q <= pwdata[WIDTH_REG_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_SCALE: prdata = APB_DATA_W'(scale_q);
			REG_WIDTH: prdata = APB_DATA_W'(in_width_q);
			default:   prdata = '0;
		endcase
	end

	// ---------------- effective settings ----------------
	// zero acts as one, values beyond the build limits are clamped
	always_comb begin
		if (in_width_q == '0) begin
			eff_w = CW'(1);
		end else if (32'(in_width_q) > MAX_WIDTH) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = CW'(in_width_q);
		end
		if (scale_q == '0) begin
			eff_s = SW'(1);
		end else if (32'(scale_q) > MAX_SCALE) begin
			eff_s = SW'(MAX_SCALE);
		end else begin
			eff_s = SW'(scale_q);
		end
	end

	// row bytes are 3*w*s; the padding to 4 is (w*s) mod 4
	assign pad_c = 2'(eff_w[1:0] * eff_s[1:0]);

	// ---------------- request decode ----------------
	// the result register frees up whenever its result is taken
	assign pix_in.ready = !valid_s1 || pix_out.ready;
	assign accept       = pix_in.valid && pix_in.ready;
	assign is_push      = (cmd_t'(pix_in.cmd) == CMD_PUSH);
	assign push_ok      = accept && is_push && !row_ready_q;
	assign pull_ok      = accept && !is_push && row_ready_q;

	assign fill_done = (CW'(fill_q) + CW'(1)) == eff_w;
	assign col_last  = (SW'(col_rep_q) + SW'(1)) >= eff_s;
	assign col_wrap  = col_last && ((CW'(col_q) + CW'(1)) >= eff_w);
	assign row_last  = (SW'(row_rep_q) + SW'(1)) >= eff_s;

	// ---------------- row control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			row_ready_q <= 1'b0;
			col_q       <= '0;
			col_rep_q   <= '0;
			row_rep_q   <= '0;
		end else if (cfg_wr) begin
			// any register write abandons the row in progress
			fill_q      <= '0;
			row_ready_q <= 1'b0;
			col_q       <= '0;
			col_rep_q   <= '0;
			row_rep_q   <= '0;
		end else if (push_ok) begin
			if (fill_done) begin
				fill_q      <= '0;
				row_ready_q <= 1'b1;
				col_q       <= '0;
				col_rep_q   <= '0;
				row_rep_q   <= '0;
			end else begin
				fill_q <= fill_q + AW'(1);
			end
		end else if (pull_ok) begin
			if (!col_last) begin
				col_rep_q <= col_rep_q + RPW'(1);
			end else begin
				col_rep_q <= '0;
				if (!col_wrap) begin
					col_q <= col_q + AW'(1);
				end else begin
					col_q <= '0;
					if (!row_last) begin
						row_rep_q <= row_rep_q + RPW'(1);
					end else begin
						// last replay done, buffer free for the next row
						row_rep_q   <= '0;
						row_ready_q <= 1'b0;
					end
				end
			end
		end
	end

	// ---------------- line buffer ----------------
	// pushes only happen with no ready row and pulls only with one, so the
	// write and a read of the same entry never share a cycle
	ipru_line_buf #(
		.DEPTH (MAX_WIDTH)
	) u_line_buf (
		.clk   (clk),
		.we    (push_ok),
		.waddr (fill_q),
		.wdata ({pix_in.in_red, pix_in.in_green, pix_in.in_blue}),
		.re    (pull_ok),
		.raddr (col_q),
		.rdata (rd_pix)
	);

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (push_ok) begin
				status_s1 <= ST_STORED;
			end else if (pull_ok) begin
				status_s1 <= ST_PIXEL;
			end else begin
				status_s1 <= ST_REFUSED;
			end
			row_end_s1   <= pull_ok && col_wrap;
			group_end_s1 <= pull_ok && col_wrap && row_last;
			pad_s1       <= (pull_ok && col_wrap) ? pad_c : 2'd0;
		end
	end

	// pixel bytes read as zero unless the result is an output pixel
	assign pix_out.valid     = valid_s1;
	assign pix_out.status    = status_s1;
	assign pix_out.out_blue  = (status_s1 == ST_PIXEL) ? rd_pix[7:0]   : 8'd0;
	assign pix_out.out_green = (status_s1 == ST_PIXEL) ? rd_pix[15:8]  : 8'd0;
	assign pix_out.out_red   = (status_s1 == ST_PIXEL) ? rd_pix[23:16] : 8'd0;
	assign pix_out.row_end   = row_end_s1;
	assign pix_out.group_end = group_end_s1;
	assign pix_out.pad_bytes = pad_s1;

	// ---------------- assertions ----------------
	`IPRU_ASSERT_IMPL(a_ready_row_unfilled, row_ready_q, fill_q == '0, "fill count moved during replay")
	`IPRU_ASSERT_NEXT(a_push_stored, push_ok && !cfg_wr, valid_s1 && status_s1 == ST_STORED, "accepted push not reported stored")
	`IPRU_ASSERT_NEXT(a_group_frees, pull_ok && col_wrap && row_last && !cfg_wr, !row_ready_q, "buffer still busy after last replay")
	`IPRU_ASSERT_IMPL(a_group_in_row, valid_s1 && group_end_s1, row_end_s1 && status_s1 == ST_PIXEL, "group end off a row end")

endmodule
